[src/cdq_pkg.sv]
// Shared types and constants for the circular deque.
package cdq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int CAP_W     = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_REAR  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_REAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	// One request as it travels down the row of cells.
	typedef struct packed {
		logic              valid;
		kind_t             kind;
		status_t           status;
		logic [DATA_W-1:0] data;
	} item_t;

endpackage

[src/cdq_ctrl.sv]
// Index control: capacity register, front/rear indices and empty flag.
module cdq_ctrl
	import cdq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [1:0]        operation,
	input  logic [DATA_W-1:0] push_value,
	input  logic              cfg_wen,
	input  logic [CAP_W-1:0]  cfg_wdata,
	output item_t             item,
	output logic [AW-1:0]     slot
);

	localparam int DW = $clog2(DEPTH + 1);
	localparam int CW = (CAP_W > DW) ? CAP_W : DW;

	logic [CAP_W-1:0] capacity_q;
	logic [AW-1:0]    front_q, rear_q;
	logic             empty_q;
	logic [AW-1:0]    front_d, rear_d;
	logic             empty_d;

	logic [CW-1:0] cap_ext, cap_eff, front_ext, rear_ext;
	logic [CW-1:0] front_inc, rear_inc;
	logic [AW-1:0] cap_last, fwd_front, fwd_rear, back_front, back_rear;
	logic          full;

	always_comb begin
		cap_ext = CW'(capacity_q);
		if (cap_ext < CW'(2)) begin
			cap_eff = CW'(2);
		end else if (cap_ext > CW'(DEPTH)) begin
			cap_eff = CW'(DEPTH);
		end else begin
			cap_eff = cap_ext;
		end
	end

	assign cap_last  = AW'(cap_eff - CW'(1));
	assign front_ext = CW'(front_q);
	assign rear_ext  = CW'(rear_q);
	assign front_inc = front_ext + CW'(1);
	assign rear_inc  = rear_ext + CW'(1);

	// Steps wrap inside the capacity in use; a stale index beyond it steps back to the end.
	assign fwd_front  = (front_inc >= cap_eff) ? '0 : AW'(front_inc);
	assign fwd_rear   = (rear_inc >= cap_eff) ? '0 : AW'(rear_inc);
	assign back_front = (front_q == '0 || front_ext > cap_eff) ? cap_last : front_q - AW'(1);
	assign back_rear  = (rear_q == '0 || rear_ext > cap_eff) ? cap_last : rear_q - AW'(1);
	assign full       = (fwd_rear == front_q);

	always_comb begin
		front_d     = front_q;
		rear_d      = rear_q;
		empty_d     = empty_q;
		item.valid  = accept;
		item.kind   = KIND_NONE;
		item.status = ST_DONE;
		item.data   = push_value;
		slot        = '0;
		case (op_t'(operation))
			OP_PUSH_FRONT, OP_PUSH_REAR: begin
				if (empty_q) begin
					front_d   = '0;
					rear_d    = '0;
					empty_d   = 1'b0;
					item.kind = KIND_WRITE;
				end else if (full) begin
					item.status = ST_FULL;
				end else if (op_t'(operation) == OP_PUSH_FRONT) begin
					front_d   = back_front;
					slot      = back_front;
					item.kind = KIND_WRITE;
				end else begin
					rear_d    = fwd_rear;
					slot      = fwd_rear;
					item.kind = KIND_WRITE;
				end
			end
			OP_POP_FRONT, OP_POP_REAR: begin
				if (empty_q) begin
					item.status = ST_EMPTY;
				end else begin
					item.kind = KIND_READ;
					slot      = (op_t'(operation) == OP_POP_FRONT) ? front_q : rear_q;
					if (front_q == rear_q) begin
						front_d = '0;
						rear_d  = '0;
						empty_d = 1'b1;
					end else if (op_t'(operation) == OP_POP_FRONT) begin
						front_d = fwd_front;
					end else begin
						rear_d = back_rear;
					end
				end
			end
			default: begin
				item.kind = KIND_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			front_q    <= '0;
			rear_q     <= '0;
			empty_q    <= 1'b1;
		end else begin
			if (cfg_wen) begin
				capacity_q <= cfg_wdata;
			end
			if (accept) begin
				front_q <= front_d;
				rear_q  <= rear_d;
				empty_q <= empty_d;
			end
		end
	end

endmodule

[src/cdq_cell.sv]
// One store entry of the deque with its stage of the request pipeline.
module cdq_cell
	import cdq_pkg::*;
#(
	parameter int AW  = 4,
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  item_t         in_item,
	input  logic [AW-1:0] in_slot,
	output item_t         out_item,
	output logic [AW-1:0] out_slot
);

	logic [DATA_W-1:0] entry_q;
	logic              valid_q;
	kind_t             kind_q;
	status_t           status_q;
	logic [DATA_W-1:0] data_q;
	logic [AW-1:0]     slot_q;
	logic              hit;

	assign hit = in_item.valid && (in_slot == AW'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= in_item.valid;
		end
	end

	// Requests pass every cell in order, so reads here always see earlier writes.
	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q   <= in_item.kind;
			status_q <= in_item.status;
			slot_q   <= in_slot;
			if (hit && in_item.kind == KIND_READ) begin
				data_q <= entry_q;
			end else begin
				data_q <= in_item.data;
			end
			if (hit && in_item.kind == KIND_WRITE) begin
				entry_q <= in_item.data;
			end
		end
	end

	assign out_item.valid  = valid_q;
	assign out_item.kind   = kind_q;
	assign out_item.status = status_q;
	assign out_item.data   = data_q;
	assign out_slot        = slot_q;

endmodule

[src/circular_deque.sv]
// Top level of the circular deque: index control followed by a row of store cells.
// The first cell loads a request at the edge that accepts it; the request then passes through
// the remaining cells in order to the output, where it waits until the result side takes it.
// Throughput: one request per cycle while the result side takes results; the whole row
// holds while a result waits. Reset empties the deque, zeroes both indices, sets the
// capacity to 16 and drops requests in flight; store contents are not cleared.
module circular_deque
	import cdq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [39:0]      s_tdata,   // operation[1:0], push_value[33:2], zeros above
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [39:0]      m_tdata,   // popped_value[31:0], status[33:32], zeros above
	input  logic             cfg_wen,
	input  logic [CAP_W-1:0] cfg_wdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	item_t         chain_item [0:DEPTH];
	logic [AW-1:0] chain_slot [0:DEPTH];
	logic          advance;
	logic          accept;
	item_t         last;

	assign last     = chain_item[DEPTH];
	assign advance  = !last.valid || m_tready;
	assign s_tready = advance;
	assign accept   = s_tvalid && advance;

	cdq_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.operation  (s_tdata[1:0]),
		.push_value (s_tdata[33:2]),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.item       (chain_item[0]),
		.slot       (chain_slot[0])
	);

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		cdq_cell #(
			.AW  (AW),
			.IDX (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.in_item  (chain_item[k]),
			.in_slot  (chain_slot[k]),
			.out_item (chain_item[k+1]),
			.out_slot (chain_slot[k+1])
		);
	end

	assign m_tvalid = last.valid;
	assign m_tdata  = {6'b0, last.status,
		(last.kind == KIND_READ) ? last.data : {DATA_W{1'b0}}};

endmodule

[src/cdq_checker.sv]
// Port-level checks for the circular deque, bound to the top level.
module cdq_props (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// A result that is not taken stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The input side is held back only by a waiting result.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow the output stall");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[33:32] != 2'd3)
		else $error("status code out of range");

	// A rejected request never carries a value.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33:32] != 2'd0 |-> m_tdata[31:0] == 32'd0)
		else $error("rejected request returned a value");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:34] == 6'd0)
		else $error("padding bits of the result are not zero");

endmodule

bind circular_deque cdq_props u_cdq_props (.*);

[verif/cdq_checker.sv]
// Checker for the circular deque: predicts each result and compares it with the output stream.
module cdq_checker
	import cdq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [39:0]      s_tdata,   // operation[1:0], push_value[33:2], zeros above
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [39:0]      m_tdata,   // popped_value[31:0], status[33:32], zeros above
	input  logic             cfg_wen,
	input  logic [CAP_W-1:0] cfg_wdata,
	output int               fail_count,
	output int               pending,
	output int               occupancy
);

	typedef struct packed {
		logic [DATA_W-1:0] popped;
		status_t           status;
	} deque_result_t;

	deque_result_t expected_q[$];
	deque_result_t want;
	deque_result_t got;

	logic [DATA_W-1:0] held[DEPTH];
	int unsigned       head_ix;
	int unsigned       tail_ix;
	bit                is_vacant;
	logic [CAP_W-1:0]  cap_reg;
	int                errors;

	// Out-of-range capacity values are clamped into 2..DEPTH.
	function automatic int unsigned cap_in_use();
		if (cap_reg < 2) return 2;
		if (cap_reg > DEPTH) return DEPTH;
		return cap_reg;
	endfunction

	function automatic int unsigned next_ix(int unsigned i);
		if (i + 1 >= cap_in_use()) return 0;
		return i + 1;
	endfunction

	function automatic int unsigned prev_ix(int unsigned i);
		if (i == 0 || i > cap_in_use()) return cap_in_use() - 1;
		return i - 1;
	endfunction

	function automatic int unsigned store_slot(int unsigned i);
		return (i < DEPTH) ? i : 0;
	endfunction

	function automatic int fill_level();
		int d;
		if (is_vacant) return 0;
		d = int'(tail_ix) - int'(head_ix);
		if (d < 0) d += cap_in_use();
		return d + 1;
	endfunction

	// Applies one request to the predicted deque and returns the result it should give.
	function automatic deque_result_t apply_request(op_t op, logic [DATA_W-1:0] v);
		deque_result_t r;
		int unsigned   at;
		r.popped = '0;
		r.status = ST_DONE;
		if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
			if (is_vacant) begin
				head_ix   = 0;
				tail_ix   = 0;
				is_vacant = 1'b0;
				held[0]   = v;
			end else if (next_ix(tail_ix) == head_ix) begin
				r.status = ST_FULL;
			end else if (op == OP_PUSH_FRONT) begin
				head_ix = prev_ix(head_ix);
				held[store_slot(head_ix)] = v;
			end else begin
				tail_ix = next_ix(tail_ix);
				held[store_slot(tail_ix)] = v;
			end
		end else begin
			if (is_vacant) begin
				r.status = ST_EMPTY;
			end else begin
				at = (op == OP_POP_FRONT) ? head_ix : tail_ix;
				r.popped = held[store_slot(at)];
				if (head_ix == tail_ix) begin
					head_ix   = 0;
					tail_ix   = 0;
					is_vacant = 1'b1;
				end else if (op == OP_POP_FRONT) begin
					head_ix = next_ix(head_ix);
				end else begin
					tail_ix = prev_ix(tail_ix);
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (held[i]) held[i] = '0;
			head_ix    = 0;
			tail_ix    = 0;
			is_vacant  = 1'b1;
			cap_reg    = CAP_RESET;
			errors     = 0;
			expected_q.delete();
			fail_count <= 0;
			pending    <= 0;
			occupancy  <= 0;
		end else begin
			// A capacity write applies to requests after this edge.
			if (s_tvalid && s_tready)
				expected_q.push_back(apply_request(op_t'(s_tdata[1:0]), s_tdata[33:2]));
			if (cfg_wen) cap_reg = cfg_wdata;
			if (m_tvalid && m_tready) begin
				got.popped = m_tdata[31:0];
				got.status = status_t'(m_tdata[33:32]);
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: popped %h status %0d", got.popped, got.status);
				end else begin
					want = expected_q.pop_front();
					if (want.popped !== got.popped || want.status !== got.status) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected popped %h status %0d, got popped %h status %0d",
								want.popped, want.status, got.popped, got.status);
					end
				end
			end
			// Outputs change after the edge so the stimulus side always sees a settled view.
			fail_count <= errors;
			pending    <= expected_q.size();
			occupancy  <= fill_level();
		end
	end

endmodule

[verif/tb_circular_deque.sv]
// Testbench top for the circular deque: clock, reset, request stimulus and final verdict.
module tb_circular_deque;
	import cdq_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEM_GOAL   = 1350;
	localparam int QUIET_AFTER = 1150;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [39:0]      s_tdata;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [39:0]      m_tdata;
	logic             cfg_wen;
	logic [CAP_W-1:0] cfg_wdata;

	int fail_count;
	int pending;
	int occupancy;
	bit quiet = 1'b0;
	int cycle_count = 0;
	int items_sent = 0;
	int stall_left = 0;

	circular_deque #(.DEPTH(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	cdq_checker #(.DEPTH(DEPTH)) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.fail_count(fail_count),
		.pending   (pending),
		.occupancy (occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// The result side stalls in short random bursts until the quiet part of the run.
	always @(posedge clk) begin
		if (!quiet && stall_left == 0 && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 3);
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Presents one request until accepted; outside quiet runs it may then drop valid.
	task automatic send_req(input op_t op, input logic [DATA_W-1:0] v);
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, v, op};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Pops until the deque holds nothing, so capacity can be changed safely.
	task automatic empty_deque();
		int n;
		wait_drained();
		while (occupancy > 0) begin
			n = occupancy;
			repeat (n) send_req($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR, pick_value());
			wait_drained();
		end
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] c);
		empty_deque();
		cfg_wen   <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_wen   <= 1'b0;
	endtask

	task automatic run_phase(input int length);
		int mode;
		int run_left;
		int push_pct;
		op_t op;
		run_left = 0;
		mode     = 0;
		repeat (length) begin
			if (run_left == 0) begin
				mode     = $urandom_range(0, 2);
				run_left = $urandom_range(4, 24);
			end
			run_left--;
			// Fill runs drive the deque to full, drain runs to empty, mixed runs wander.
			push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
			if ($urandom_range(1, 100) <= push_pct)
				op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
			else
				op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
			send_req(op, pick_value());
			if (items_sent >= QUIET_AFTER) quiet <= 1'b1;
		end
	endtask

	initial begin
		logic [CAP_W-1:0] caps[8];
		int phase;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_wen   = 1'b0;
		cfg_wdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset capacity: pops on empty, extremes, emptying from the rear.
		send_req(OP_POP_FRONT, 32'h0);
		send_req(OP_POP_REAR, 32'hFFFF_FFFF);
		send_req(OP_PUSH_FRONT, 32'h7FFF_FFFF);
		send_req(OP_PUSH_REAR, 32'h8000_0000);
		send_req(OP_PUSH_FRONT, 32'hFFFF_FFFF);
		send_req(OP_POP_FRONT, 32'h0);
		send_req(OP_POP_REAR, 32'h0);
		send_req(OP_POP_REAR, 32'h0);
		send_req(OP_POP_FRONT, 32'h0);
		send_req(OP_PUSH_FRONT, 32'h0000_0000);
		send_req(OP_POP_REAR, 32'h0);

		// Smallest capacity: the second push already fills the deque.
		set_capacity(5'd2);
		send_req(OP_PUSH_REAR, 32'h1234_5678);
		send_req(OP_PUSH_FRONT, 32'hEDCB_A987);
		send_req(OP_PUSH_REAR, 32'h5555_5555);
		send_req(OP_PUSH_FRONT, 32'hAAAA_AAAA);
		send_req(OP_POP_FRONT, 32'h0);
		send_req(OP_POP_FRONT, 32'h0);
		send_req(OP_POP_FRONT, 32'h0);

		// Capacity values outside the legal range are clamped by the block.
		set_capacity(5'd0);
		send_req(OP_PUSH_FRONT, 32'h0F0F_0F0F);
		send_req(OP_PUSH_FRONT, 32'hF0F0_F0F0);
		send_req(OP_PUSH_FRONT, 32'h3333_3333);
		set_capacity(5'd31);
		run_phase(20);

		caps = '{5'd2, 5'd16, 5'd1, 5'd3, 5'd31, 5'd17, 5'd0, 5'd16};
		phase = 0;
		while (items_sent < ITEM_GOAL) begin
			if (phase < 8)
				set_capacity(caps[phase]);
			else if ($urandom_range(0, 3) == 0)
				set_capacity(CAP_W'($urandom_range(0, 31)));
			else
				set_capacity(CAP_W'($urandom_range(2, 8)));
			run_phase($urandom_range(60, 150));
			phase++;
		end

		wait_drained();
		repeat (DEPTH + 8) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[sim.f]
src/cdq_pkg.sv
src/cdq_ctrl.sv
src/cdq_cell.sv
src/circular_deque.sv
src/cdq_checker.sv
verif/cdq_checker.sv
verif/tb_circular_deque.sv
